// ----- sv/shfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfp_pkg
// Shared constants and types for the sync-header frame parser: header bytes,
// the status command code, field widths and the decoded result record.
// ----------------------------------------------------------------------------
package shfp_pkg;

    localparam int BYTE_W          = 8;
    localparam int WORD_W          = 16;
    localparam int LEN_W           = 5;   // frame length and payload count width
    localparam int PAYLOAD_MAX_DEF = 20;  // default payload buffer depth

    // Header and command codes
    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;
    localparam logic [BYTE_W-1:0] CMD_STATUS  = 8'h04;
    localparam logic [LEN_W-1:0]  STATUS_LEN  = 5'd19;

    // Status frame layout: nine big-endian words, then the mode byte
    localparam int WORD_CNT = 9;
    localparam int MODE_IDX = 18;

    typedef struct packed {
        logic [WORD_CNT-1:0][WORD_W-1:0] words;
        logic [BYTE_W-1:0]               mode;
    } t_result;

endpackage

// ----- sv/shfp_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfp_parser
// Frame state machine: header hunt, command and length capture, payload
// buffering with a running 8-bit sum, and the checksum test that flags a
// good status frame. The decoded status record is read from the buffer.
// ----------------------------------------------------------------------------
module shfp_parser
    import shfp_pkg::*;
#(
    parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,     // consume i_byte this cycle
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_hit,      // i_byte closes a good status frame
    output t_result           o_result
);

    localparam int IDX_W = $clog2(PAYLOAD_MAX);

    // Parse phases
    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_EXPECT  = 3'd1;
    localparam logic [2:0] PH_CMD     = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CHECK   = 3'd5;

    logic [2:0]        r_phase, n_phase;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_cmd, n_cmd;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_count, n_count;
    logic [LEN_W-1:0]  w_count_inc;
    logic [BYTE_W-1:0] w_sum_add;
    logic              w_wr_en;
    logic              w_hit;

    logic [BYTE_W-1:0] r_store [PAYLOAD_MAX];

    assign w_sum_add   = r_sum + i_byte;
    assign w_count_inc = r_count + 1'b1;

    // Next-state logic for one received byte
    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_count = r_count;
        w_wr_en = 1'b0;
        w_hit   = 1'b0;
        case (r_phase)
            PH_HUNT: begin
                if (i_byte == SYNC_FIRST) begin
                    n_phase = PH_EXPECT;
                    n_sum   = i_byte;
                end
            end
            PH_EXPECT: begin
                if (i_byte == SYNC_SECOND) begin
                    n_phase = PH_CMD;
                    n_sum   = w_sum_add;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_CMD: begin
                n_cmd   = i_byte;
                n_sum   = w_sum_add;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                if (i_byte > BYTE_W'(PAYLOAD_MAX)) begin
                    // oversized frame: drop, keep old length
                    n_phase = PH_HUNT;
                    n_sum   = '0;
                end else begin
                    n_len   = i_byte[LEN_W-1:0];
                    n_sum   = w_sum_add;
                    n_count = '0;
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                // zero length still takes one byte
                w_wr_en = (r_count < LEN_W'(PAYLOAD_MAX));
                n_count = w_count_inc;
                n_sum   = w_sum_add;
                if (w_count_inc >= r_len) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                w_hit   = (i_byte == r_sum) && (r_cmd == CMD_STATUS) &&
                          (r_len == STATUS_LEN);
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_sum   <= '0;
            r_cmd   <= '0;
            r_len   <= '0;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_count <= n_count;
        end
    end

    // Payload buffer, one write per payload byte
    always_ff @(posedge i_clk) begin
        if (i_step && w_wr_en) begin
            r_store[r_count[IDX_W-1:0]] <= i_byte;
        end
    end

    // Status record: big-endian word pairs and the mode byte
    always_comb begin
        for (int k = 0; k < WORD_CNT; k++) begin
            o_result.words[k] = {r_store[2*k], r_store[2*k+1]};
        end
        o_result.mode = r_store[MODE_IDX];
    end

    assign o_hit = w_hit;

    // While buffering, the count has not yet reached the length
    // (a zero-length frame sits at count zero).
    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> ((r_count < r_len) || (r_count == '0)))
        else $error("payload count passed frame length");

    // The checksum phase is only reached with the full payload taken
    a_check_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CHECK) |-> (r_count >= r_len))
        else $error("checksum phase with short payload");

endmodule

// ----- sv/sync_header_frame_parser_unit.sv -----
`timescale 1ns / 1ps
// Result path: the checksum byte passes the input byte register, then the result register.
// Throughput: one byte per cycle; the input side stalls only when a good frame
//   ends while the previous result still waits in the output register.
// Reset: synchronous, active low; clears parser control state and both valid
//   flags. The payload buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// sync_header_frame_parser_unit
// Top level: input byte register, frame parser and the result register that
// holds the decoded status record until it is transferred.
// ----------------------------------------------------------------------------
module sync_header_frame_parser_unit
    import shfp_pkg::*;
#(
    parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte input
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    // status record output
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_angle,
    output logic [WORD_W-1:0] o_location,
    output logic [WORD_W-1:0] o_target_position,
    output logic [WORD_W-1:0] o_angle_gain_p,
    output logic [WORD_W-1:0] o_angle_gain_i,
    output logic [WORD_W-1:0] o_angle_gain_d,
    output logic [WORD_W-1:0] o_position_gain_p,
    output logic [WORD_W-1:0] o_position_gain_i,
    output logic [WORD_W-1:0] o_position_gain_d,
    output logic [BYTE_W-1:0] o_op_mode
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;

    logic              w_hit;
    t_result           w_result;
    logic              w_out_free;
    logic              w_advance;

    shfp_parser #(
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_byte   (r_in_byte),
        .o_hit    (w_hit),
        .o_result (w_result)
    );

    // Held byte moves on unless it produces a result with no room for it
    assign w_out_free = !r_out_valid || i_ready;
    assign w_advance  = r_in_valid && (!w_hit || w_out_free);
    assign o_ready    = !r_in_valid || w_advance;

    // Input byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_hit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_hit) begin
            r_out <= w_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_angle           = r_out.words[0];
    assign o_location        = r_out.words[1];
    assign o_target_position = r_out.words[2];
    assign o_angle_gain_p    = r_out.words[3];
    assign o_angle_gain_i    = r_out.words[4];
    assign o_angle_gain_d    = r_out.words[5];
    assign o_position_gain_p = r_out.words[6];
    assign o_position_gain_i = r_out.words[7];
    assign o_position_gain_d = r_out.words[8];
    assign o_op_mode         = r_out.mode;

    // A new result always comes from a held input byte
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without an input byte");

    // A held byte that cannot advance stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("stalled input byte lost or changed");

    // Back-pressure only when a result is blocked at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_valid && r_out_valid && !i_ready))
        else $error("input stalled without a blocked result");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sync-header frame parser. Bytes are sent in
// bursts with random gaps while the result side stalls on its own pattern.
// A scoreboard parses every transferred byte the way the parser should and
// queues the status records it expects. Each record that comes out is then
// checked field by field against the oldest one queued.
// ----------------------------------------------------------------------------
module testbench;
    import shfp_pkg::*;

    // Status record expectations, built from the transferred byte stream
    class frame_scoreboard;
        localparam int PAYLOAD_MAX = PAYLOAD_MAX_DEF;

        typedef enum logic [2:0] {
            PH_HUNT  = 3'd0,
            PH_SYNC2 = 3'd1,
            PH_CMD   = 3'd2,
            PH_LEN   = 3'd3,
            PH_DATA  = 3'd4,
            PH_SUM   = 3'd5
        } t_phase;

        t_phase             phase;
        logic [BYTE_W-1:0]  sum;
        logic [BYTE_W-1:0]  cmd;
        logic [LEN_W-1:0]   flen;
        logic [LEN_W-1:0]   cnt;
        logic [BYTE_W-1:0]  store [PAYLOAD_MAX];
        t_result            expected_records [$];
        int                 errors;
        string              word_name [WORD_CNT];

        function new();
            phase = PH_HUNT;
            sum   = '0;
            cmd   = '0;
            flen  = '0;
            cnt   = '0;
            foreach (store[i]) store[i] = '0;
            errors = 0;
            word_name = '{"angle", "location", "target_position", "angle_gain_p",
                          "angle_gain_i", "angle_gain_d", "position_gain_p",
                          "position_gain_i", "position_gain_d"};
        endfunction

        task report(string msg);
            if (errors < 50) $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function int pending();
            return expected_records.size();
        endfunction

        // One transferred byte through the parser's state machine
        function void take_byte(logic [BYTE_W-1:0] b);
            t_result rec;
            case (phase)
                PH_HUNT: begin
                    if (b == SYNC_FIRST) begin
                        phase = PH_SYNC2;
                        sum   = b;
                    end
                end
                PH_SYNC2: begin
                    // a mismatch drops back to hunting without re-testing b
                    if (b == SYNC_SECOND) begin
                        phase = PH_CMD;
                        sum   = sum + b;
                    end else begin
                        phase = PH_HUNT;
                    end
                end
                PH_CMD: begin
                    cmd   = b;
                    sum   = sum + b;
                    phase = PH_LEN;
                end
                PH_LEN: begin
                    if (b > PAYLOAD_MAX) begin
                        // oversize: drop, sum cleared, length kept
                        phase = PH_HUNT;
                        sum   = '0;
                    end else begin
                        flen  = b[LEN_W-1:0];
                        sum   = sum + b;
                        cnt   = '0;
                        phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    // zero length still takes one byte here
                    if (cnt < PAYLOAD_MAX) store[cnt] = b;
                    cnt = cnt + 1'b1;
                    sum = sum + b;
                    if (cnt >= flen) phase = PH_SUM;
                end
                PH_SUM: begin
                    if (b == sum && cmd == CMD_STATUS && flen == STATUS_LEN) begin
                        for (int k = 0; k < WORD_CNT; k++)
                            rec.words[k] = {store[2*k], store[2*k+1]};
                        rec.mode = store[MODE_IDX];
                        expected_records.push_back(rec);
                    end
                    phase = PH_HUNT;
                end
                default: phase = PH_HUNT;
            endcase
        endfunction

        // Compare one transferred record with the oldest expectation
        task check_record(t_result got);
            t_result exp;
            if (expected_records.size() == 0) begin
                report($sformatf("record with no frame behind it, angle %h",
                                 got.words[0]));
                return;
            end
            exp = expected_records.pop_front();
            for (int k = 0; k < WORD_CNT; k++)
                if (got.words[k] !== exp.words[k])
                    report($sformatf("%s: got %h, expected %h",
                                     word_name[k], got.words[k], exp.words[k]));
            if (got.mode !== exp.mode)
                report($sformatf("op_mode: got %h, expected %h", got.mode, exp.mode));
        endtask
    endclass

    typedef enum logic [1:0] {
        RDY_ALWAYS = 2'd0,
        RDY_RANDOM = 2'd1,
        RDY_SPARSE = 2'd2,
        RDY_STALL  = 2'd3
    } t_ready_mode;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              i_valid   = 1'b0;
    logic              o_ready;
    logic [BYTE_W-1:0] i_rx_byte = '0;
    logic              o_valid;
    logic              i_ready   = 1'b0;
    logic [WORD_W-1:0] o_angle;
    logic [WORD_W-1:0] o_location;
    logic [WORD_W-1:0] o_target_position;
    logic [WORD_W-1:0] o_angle_gain_p;
    logic [WORD_W-1:0] o_angle_gain_i;
    logic [WORD_W-1:0] o_angle_gain_d;
    logic [WORD_W-1:0] o_position_gain_p;
    logic [WORD_W-1:0] o_position_gain_i;
    logic [WORD_W-1:0] o_position_gain_d;
    logic [BYTE_W-1:0] o_op_mode;

    frame_scoreboard sb = new();
    int              burst_left = 0;
    int              bytes_sent = 0;
    t_ready_mode     ready_mode = RDY_ALWAYS;
    int              ready_hold = 0;
    logic [1:0]      ready_phase = '0;
    t_result         seen_record;

    sync_header_frame_parser_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_rx_byte         (i_rx_byte),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_angle           (o_angle),
        .o_location        (o_location),
        .o_target_position (o_target_position),
        .o_angle_gain_p    (o_angle_gain_p),
        .o_angle_gain_i    (o_angle_gain_i),
        .o_angle_gain_d    (o_angle_gain_d),
        .o_position_gain_p (o_position_gain_p),
        .o_position_gain_i (o_position_gain_i),
        .o_position_gain_d (o_position_gain_d),
        .o_op_mode         (o_op_mode)
    );

    always #6 i_clk = ~i_clk;

    // Receiver: switches at random between four ready patterns
    always @(posedge i_clk) begin
        ready_phase <= ready_phase + 1'b1;
        if (ready_hold == 0) begin
            ready_mode <= t_ready_mode'($urandom_range(0, 3));
            ready_hold <= $urandom_range(32, 200);
        end else begin
            ready_hold <= ready_hold - 1;
        end
        case (ready_mode)
            RDY_ALWAYS: i_ready <= 1'b1;
            RDY_RANDOM: i_ready <= 1'($urandom_range(0, 1));
            RDY_SPARSE: i_ready <= (ready_phase == 2'd0);
            default:    i_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_record.words[0] = o_angle;
            seen_record.words[1] = o_location;
            seen_record.words[2] = o_target_position;
            seen_record.words[3] = o_angle_gain_p;
            seen_record.words[4] = o_angle_gain_i;
            seen_record.words[5] = o_angle_gain_d;
            seen_record.words[6] = o_position_gain_p;
            seen_record.words[7] = o_position_gain_i;
            seen_record.words[8] = o_position_gain_d;
            seen_record.mode     = o_op_mode;
            sb.check_record(seen_record);
        end
    end

    // Send one byte; bursts of random length with random gaps in between
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        sb.take_byte(b);
        burst_left--;
        bytes_sent++;
    endtask

    // Full frame with its checksum; sum_flip nonzero corrupts the checksum
    task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] len,
                              input logic [BYTE_W-1:0] body [$],
                              input logic [BYTE_W-1:0] sum_flip);
        logic [BYTE_W-1:0] sum;
        sum = SYNC_FIRST + SYNC_SECOND + cmd + len;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(cmd);
        send_byte(len);
        foreach (body[i]) begin
            send_byte(body[i]);
            sum = sum + body[i];
        end
        send_byte(sum ^ sum_flip);
    endtask

    // Payload byte, biased toward the extremes
    function automatic logic [BYTE_W-1:0] rand_data();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin : main
        logic [BYTE_W-1:0] body [$];
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] b;
        int                kind;
        int                n;
        int                waited;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero length takes one payload byte, no record
        body = '{8'h5A};
        send_frame(CMD_STATUS, 8'd0, body, 8'h00);
        // Second header byte mismatch; the repeated 0xAA is not a new start
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        // Good status frame with extreme words and mode
        body.delete();
        for (int i = 0; i < 19; i++)
            body.push_back((i < 2) ? 8'h00 : (i < 4 || i == MODE_IDX) ? 8'hFF :
                           (i[0] ? 8'hA5 : 8'h5A));
        send_frame(CMD_STATUS, 8'(STATUS_LEN), body, 8'h00);
        // Oversize length drops the frame
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(CMD_STATUS);
        send_byte(8'd21);

        // Random frames, mostly well formed
        while (bytes_sent < 1300) begin
            kind = $urandom_range(0, 99);
            body.delete();
            if (kind < 61) begin
                // status frames: good, bad checksum, or other command
                for (int i = 0; i < 19; i++) body.push_back(rand_data());
                cmd = (kind >= 53) ? 8'($urandom_range(0, 255)) : CMD_STATUS;
                send_frame(cmd, 8'(STATUS_LEN), body,
                           (kind >= 45 && kind < 53) ? 8'($urandom_range(1, 255)) : 8'h00);
            end else if (kind < 73) begin
                // other lengths up to the buffer depth
                len = 8'($urandom_range(0, 20));
                n = (len == 0) ? 1 : int'(len);
                for (int i = 0; i < n; i++) body.push_back(rand_data());
                cmd = $urandom_range(0, 1) ? CMD_STATUS : 8'($urandom_range(0, 255));
                send_frame(cmd, len, body, 8'h00);
            end else if (kind < 79) begin
                // oversize length, followed by leftover bytes
                send_byte(SYNC_FIRST);
                send_byte(SYNC_SECOND);
                send_byte(CMD_STATUS);
                send_byte(8'($urandom_range(21, 255)));
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++) send_byte(rand_data());
            end else if (kind < 87) begin
                // broken header, then a good frame
                send_byte(SYNC_FIRST);
                b = 8'($urandom_range(0, 255));
                if (b == SYNC_SECOND || $urandom_range(0, 2) == 0) b = SYNC_FIRST;
                send_byte(b);
                for (int i = 0; i < 19; i++) body.push_back(rand_data());
                send_frame(CMD_STATUS, 8'(STATUS_LEN), body, 8'h00);
            end else if (kind < 95) begin
                // line noise
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
            end else begin
                // truncated frame; the next frame lands in its payload
                send_byte(SYNC_FIRST);
                send_byte(SYNC_SECOND);
                send_byte(CMD_STATUS);
                send_byte(8'(STATUS_LEN));
                n = $urandom_range(0, 18);
                for (int i = 0; i < n; i++) send_byte(rand_data());
            end
        end
        i_valid <= 1'b0;

        // Drain, then wait for anything stray
        waited = 0;
        while (sb.pending() > 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (sb.pending() > 0)
            sb.report($sformatf("%0d expected records never arrived", sb.pending()));

        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/shfp_pkg.sv
sv/shfp_parser.sv
sv/sync_header_frame_parser_unit.sv
dv/testbench.sv
